[hdl/mfsgd_pkg.sv]
// ----------------------------------------------------------------------------
// mfsgd_pkg
// Shared types, codes and arithmetic helpers for the matrix factorization
// SGD engine.
// ----------------------------------------------------------------------------
package mfsgd_pkg;

   localparam int DEF_MAX_USERS   = 1024;
   localparam int DEF_MAX_ITEMS   = 1024;
   localparam int DEF_MAX_FACTORS = 32;

   localparam logic [2:0] CMD_LOAD_USER_FACTOR = 3'd0;
   localparam logic [2:0] CMD_LOAD_ITEM_FACTOR = 3'd1;
   localparam logic [2:0] CMD_LOAD_USER_BIAS   = 3'd2;
   localparam logic [2:0] CMD_LOAD_ITEM_BIAS   = 3'd3;
   localparam logic [2:0] CMD_TRAIN            = 3'd4;
   localparam logic [2:0] CMD_PREDICT          = 3'd5;

   localparam logic [2:0] CSR_NUM_USERS      = 3'd0;
   localparam logic [2:0] CSR_NUM_ITEMS      = 3'd1;
   localparam logic [2:0] CSR_NUM_FACTORS    = 3'd2;
   localparam logic [2:0] CSR_GLOBAL_MEAN    = 3'd3;
   localparam logic [2:0] CSR_LEARNING_RATE  = 3'd4;
   localparam logic [2:0] CSR_REGULARIZATION = 3'd5;

   typedef struct packed {
      logic [2:0]         command;
      logic [9:0]         user_index;
      logic [9:0]         item_index;
      logic [4:0]         factor_index;
      logic signed [31:0] load_value;
      logic signed [31:0] rating_value;
   } req_type;

   typedef struct packed {
      logic signed [31:0] prediction;
      logic signed [31:0] error;
      logic               status;
   } rsp_type;

   typedef enum logic [4:0] {
      S_IDLE, S_DECODE, S_LOAD, S_ABORT, S_BIAS_RD, S_DOT_RD, S_DOT_MUL,
      S_DOT_ACC, S_PRED, S_ERR, S_UPD_RD, S_UPD_M1, S_UPD_M2, S_UPD_G,
      S_UPD_M3, S_UPD_WR, S_BIAS_M1, S_BIAS_G, S_BIAS_M2, S_BIAS_WR, S_RESP
   } state_type;

   typedef enum logic [4:0] {
      OP_NONE, OP_LATCH, OP_LOAD, OP_ABORT, OP_BIAS_RD, OP_DOT_RD, OP_DOT_MUL,
      OP_DOT_ACC, OP_PRED, OP_ERR, OP_UPD_RD, OP_UPD_M1, OP_UPD_M2, OP_UPD_G,
      OP_UPD_M3, OP_UPD_WR, OP_BIAS_M1, OP_BIAS_G, OP_BIAS_M2, OP_BIAS_WR
   } dp_op_type;

   typedef struct packed {
      logic is_load;
      logic run_ok;
      logic is_train;
      logic nk_zero;
      logic k_last;
   } dp_status_type;

   function automatic logic signed [63:0] rnd16(input logic signed [63:0] v);
      logic signed [63:0] t;
      t = v + 64'sd32768;
      return t >>> 16;
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      logic signed [31:0] r;
      if (v > 64'sd2147483647) r = 32'sh7fffffff;
      else if (v < -64'sd2147483648) r = 32'sh80000000;
      else r = v[31:0];
      return r;
   endfunction

endpackage

[hdl/mfsgd_ctrl.sv]
// ----------------------------------------------------------------------------
// mfsgd_ctrl
// Command sequencer: walks the dot product pass, the update pass and the
// bias update, issuing at most one datapath operation per cycle.
// ----------------------------------------------------------------------------
module mfsgd_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   output logic                    rsp_strobe,
   output mfsgd_pkg::dp_op_type     op,
   input  mfsgd_pkg::dp_status_type stat
);
   import mfsgd_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else state_ff <= state_in;
   end

   always_comb begin
      state_in = state_ff;
      op       = OP_NONE;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               op       = OP_LATCH;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            if (stat.is_load) state_in = S_LOAD;
            else if (stat.run_ok) state_in = S_BIAS_RD;
            else state_in = S_ABORT;
         end
         S_LOAD: begin
            op       = OP_LOAD;
            state_in = S_RESP;
         end
         S_ABORT: begin
            op       = OP_ABORT;
            state_in = S_RESP;
         end
         S_BIAS_RD: begin
            op       = OP_BIAS_RD;
            state_in = stat.nk_zero ? S_PRED : S_DOT_RD;
         end
         S_DOT_RD: begin
            op       = OP_DOT_RD;
            state_in = S_DOT_MUL;
         end
         S_DOT_MUL: begin
            op       = OP_DOT_MUL;
            state_in = S_DOT_ACC;
         end
         S_DOT_ACC: begin
            op       = OP_DOT_ACC;
            state_in = stat.k_last ? S_PRED : S_DOT_RD;
         end
         S_PRED: begin
            op       = OP_PRED;
            state_in = stat.is_train ? S_ERR : S_RESP;
         end
         S_ERR: begin
            op       = OP_ERR;
            state_in = stat.nk_zero ? S_BIAS_M1 : S_UPD_RD;
         end
         S_UPD_RD: begin
            op       = OP_UPD_RD;
            state_in = S_UPD_M1;
         end
         S_UPD_M1: begin
            op       = OP_UPD_M1;
            state_in = S_UPD_M2;
         end
         S_UPD_M2: begin
            op       = OP_UPD_M2;
            state_in = S_UPD_G;
         end
         S_UPD_G: begin
            op       = OP_UPD_G;
            state_in = S_UPD_M3;
         end
         S_UPD_M3: begin
            op       = OP_UPD_M3;
            state_in = S_UPD_WR;
         end
         S_UPD_WR: begin
            op       = OP_UPD_WR;
            state_in = stat.k_last ? S_BIAS_M1 : S_UPD_RD;
         end
         S_BIAS_M1: begin
            op       = OP_BIAS_M1;
            state_in = S_BIAS_G;
         end
         S_BIAS_G: begin
            op       = OP_BIAS_G;
            state_in = S_BIAS_M2;
         end
         S_BIAS_M2: begin
            op       = OP_BIAS_M2;
            state_in = S_BIAS_WR;
         end
         S_BIAS_WR: begin
            op       = OP_BIAS_WR;
            state_in = S_RESP;
         end
         S_RESP: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign busy       = (state_ff != S_IDLE);
   assign rsp_strobe = (state_ff == S_RESP);

endmodule

[hdl/mfsgd_datapath.sv]
// ----------------------------------------------------------------------------
// mfsgd_datapath
// Factor and bias memories, configuration registers, two multipliers and
// the accumulate, gradient and saturation logic.
// ----------------------------------------------------------------------------
module mfsgd_datapath #(
   parameter int MAX_USERS   = mfsgd_pkg::DEF_MAX_USERS,
   parameter int MAX_ITEMS   = mfsgd_pkg::DEF_MAX_ITEMS,
   parameter int MAX_FACTORS = mfsgd_pkg::DEF_MAX_FACTORS
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_write_enable,
   input  logic [2:0]               csr_index,
   input  logic [31:0]              csr_write_data,
   input  mfsgd_pkg::req_type        req_data,
   input  mfsgd_pkg::dp_op_type      op,
   output mfsgd_pkg::dp_status_type  stat,
   output mfsgd_pkg::rsp_type        rsp_data
);
   import mfsgd_pkg::*;

   localparam int UFD  = MAX_USERS * MAX_FACTORS;
   localparam int IFD  = MAX_ITEMS * MAX_FACTORS;
   localparam int UFAW = (UFD > 1) ? $clog2(UFD) : 1;
   localparam int IFAW = (IFD > 1) ? $clog2(IFD) : 1;
   localparam int UW   = (MAX_USERS > 1) ? $clog2(MAX_USERS) : 1;
   localparam int IW   = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
   localparam int KW   = $clog2(MAX_FACTORS + 1);

   logic [10:0]        num_users_ff;
   logic [10:0]        num_items_ff;
   logic [5:0]         num_factors_ff;
   logic signed [31:0] global_mean_ff;
   logic [15:0]        eta_ff;
   logic [15:0]        lam_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         num_users_ff   <= 11'd1024;
         num_items_ff   <= 11'd1024;
         num_factors_ff <= 6'd32;
         global_mean_ff <= '0;
         eta_ff         <= 16'd655;
         lam_ff         <= 16'd1311;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_NUM_USERS:      num_users_ff   <= csr_write_data[10:0];
            CSR_NUM_ITEMS:      num_items_ff   <= csr_write_data[10:0];
            CSR_NUM_FACTORS:    num_factors_ff <= csr_write_data[5:0];
            CSR_GLOBAL_MEAN:    global_mean_ff <= csr_write_data;
            CSR_LEARNING_RATE:  eta_ff         <= csr_write_data[15:0];
            CSR_REGULARIZATION: lam_ff         <= csr_write_data[15:0];
            default: ;
         endcase
      end
   end

   // counts in use, clamped to the storage size
   logic [31:0] nu32, ni32, nk32;
   assign nu32 = (32'(num_users_ff) < 32'(MAX_USERS)) ? 32'(num_users_ff) : 32'(MAX_USERS);
   assign ni32 = (32'(num_items_ff) < 32'(MAX_ITEMS)) ? 32'(num_items_ff) : 32'(MAX_ITEMS);
   assign nk32 = (32'(num_factors_ff) < 32'(MAX_FACTORS)) ?
                 32'(num_factors_ff) : 32'(MAX_FACTORS);

   req_type req_ff;
   logic [KW-1:0] k_ff;

   always_ff @(posedge clock) begin
      if (op == OP_LATCH) req_ff <= req_data;
   end

   always_ff @(posedge clock) begin
      if (reset) k_ff <= '0;
      else if (op == OP_BIAS_RD || op == OP_ERR) k_ff <= '0;
      else if (op == OP_DOT_ACC || op == OP_UPD_WR) k_ff <= k_ff + 1'b1;
   end

   logic u_ok, i_ok, f_ok, is_pt, load_ok;
   assign u_ok  = 32'(req_ff.user_index) < nu32;
   assign i_ok  = 32'(req_ff.item_index) < ni32;
   assign f_ok  = 32'(req_ff.factor_index) < nk32;
   assign is_pt = (req_ff.command == CMD_TRAIN) || (req_ff.command == CMD_PREDICT);

   always_comb begin
      case (req_ff.command)
         CMD_LOAD_USER_FACTOR: load_ok = u_ok && f_ok;
         CMD_LOAD_ITEM_FACTOR: load_ok = i_ok && f_ok;
         CMD_LOAD_USER_BIAS:   load_ok = u_ok;
         CMD_LOAD_ITEM_BIAS:   load_ok = i_ok;
         default:              load_ok = 1'b0;
      endcase
   end

   assign stat.is_load  = (req_ff.command <= CMD_LOAD_ITEM_BIAS);
   assign stat.run_ok   = is_pt && u_ok && i_ok;
   assign stat.is_train = (req_ff.command == CMD_TRAIN);
   assign stat.nk_zero  = (nk32 == 32'd0);
   assign stat.k_last   = (32'(k_ff) + 32'd1 == nk32);

   // addresses: element f of vector n lives at n*MAX_FACTORS+f
   logic [31:0] fsel32, ua32, ia32, ub32, ib32;
   logic [UFAW-1:0] uf_addr;
   logic [IFAW-1:0] if_addr;
   logic [UW-1:0]   ub_addr;
   logic [IW-1:0]   ib_addr;
   assign fsel32  = (op == OP_LOAD) ? 32'(req_ff.factor_index) : 32'(k_ff);
   assign ua32    = 32'(req_ff.user_index) * 32'(MAX_FACTORS) + fsel32;
   assign ia32    = 32'(req_ff.item_index) * 32'(MAX_FACTORS) + fsel32;
   assign ub32    = 32'(req_ff.user_index);
   assign ib32    = 32'(req_ff.item_index);
   assign uf_addr = ua32[UFAW-1:0];
   assign if_addr = ia32[IFAW-1:0];
   assign ub_addr = ub32[UW-1:0];
   assign ib_addr = ib32[IW-1:0];

   logic signed [31:0] uf_mem [UFD];
   logic signed [31:0] if_mem [IFD];
   logic signed [31:0] ub_mem [MAX_USERS];
   logic signed [31:0] ib_mem [MAX_ITEMS];

   logic signed [31:0] p_ff, q_ff, bu_ff, bi_ff;
   logic signed [31:0] p_new, q_new, bu_new, bi_new;
   logic wr_load;
   assign wr_load = (op == OP_LOAD) && load_ok;

   always_ff @(posedge clock) begin
      if (wr_load && req_ff.command == CMD_LOAD_USER_FACTOR)
         uf_mem[uf_addr] <= req_ff.load_value;
      else if (op == OP_UPD_WR)
         uf_mem[uf_addr] <= p_new;
      if (op == OP_DOT_RD || op == OP_UPD_RD) p_ff <= uf_mem[uf_addr];
   end

   always_ff @(posedge clock) begin
      if (wr_load && req_ff.command == CMD_LOAD_ITEM_FACTOR)
         if_mem[if_addr] <= req_ff.load_value;
      else if (op == OP_UPD_WR)
         if_mem[if_addr] <= q_new;
      if (op == OP_DOT_RD || op == OP_UPD_RD) q_ff <= if_mem[if_addr];
   end

   always_ff @(posedge clock) begin
      if (wr_load && req_ff.command == CMD_LOAD_USER_BIAS)
         ub_mem[ub_addr] <= req_ff.load_value;
      else if (op == OP_BIAS_WR)
         ub_mem[ub_addr] <= bu_new;
      if (op == OP_BIAS_RD) bu_ff <= ub_mem[ub_addr];
   end

   always_ff @(posedge clock) begin
      if (wr_load && req_ff.command == CMD_LOAD_ITEM_BIAS)
         ib_mem[ib_addr] <= req_ff.load_value;
      else if (op == OP_BIAS_WR)
         ib_mem[ib_addr] <= bi_new;
      if (op == OP_BIAS_RD) bi_ff <= ib_mem[ib_addr];
   end

   // two 33x33 signed multipliers, products registered
   logic signed [31:0] err_ff, pred_ff, g_a_ff, g_b_ff;
   logic signed [63:0] t_a_ff, t_b_ff, acc_ff;
   logic signed [63:0] prod_a_ff, prod_b_ff;
   logic signed [32:0] ma_x, ma_y, mb_x, mb_y;
   logic signed [65:0] ma_p, mb_p;
   logic signed [32:0] eta_s, lam_s, err_s, p_s, q_s;

   assign eta_s = {17'b0, eta_ff};
   assign lam_s = {17'b0, lam_ff};
   assign err_s = {err_ff[31], err_ff};
   assign p_s   = {p_ff[31], p_ff};
   assign q_s   = {q_ff[31], q_ff};

   always_comb begin
      ma_x = p_s;
      ma_y = q_s;
      mb_x = err_s;
      mb_y = p_s;
      case (op)
         OP_UPD_M1: begin
            ma_x = err_s; ma_y = q_s; mb_x = err_s; mb_y = p_s;
         end
         OP_UPD_M2: begin
            ma_x = lam_s; ma_y = p_s; mb_x = lam_s; mb_y = q_s;
         end
         OP_BIAS_M1: begin
            ma_x = lam_s; ma_y = {bu_ff[31], bu_ff};
            mb_x = lam_s; mb_y = {bi_ff[31], bi_ff};
         end
         OP_UPD_M3, OP_BIAS_M2: begin
            ma_x = eta_s; ma_y = {g_a_ff[31], g_a_ff};
            mb_x = eta_s; mb_y = {g_b_ff[31], g_b_ff};
         end
         default: ;
      endcase
   end

   assign ma_p = ma_x * ma_y;
   assign mb_p = mb_x * mb_y;

   always_ff @(posedge clock) begin
      prod_a_ff <= ma_p[63:0];
      prod_b_ff <= mb_p[63:0];
   end

   assign p_new  = sat32(64'(p_ff) + rnd16(prod_a_ff));
   assign q_new  = sat32(64'(q_ff) + rnd16(prod_b_ff));
   assign bu_new = sat32(64'(bu_ff) + rnd16(prod_a_ff));
   assign bi_new = sat32(64'(bi_ff) + rnd16(prod_b_ff));

   logic signed [31:0] pred_sum;
   assign pred_sum = sat32(64'(global_mean_ff) + 64'(bu_ff) + 64'(bi_ff) + acc_ff);

   logic st_ff;

   always_ff @(posedge clock) begin
      case (op)
         OP_BIAS_RD: acc_ff <= '0;
         OP_DOT_ACC: acc_ff <= acc_ff + rnd16(prod_a_ff);
         OP_UPD_M2: begin
            t_a_ff <= rnd16(prod_a_ff);
            t_b_ff <= rnd16(prod_b_ff);
         end
         OP_UPD_G: begin
            g_a_ff <= sat32(t_a_ff - rnd16(prod_a_ff));
            g_b_ff <= sat32(t_b_ff - rnd16(prod_b_ff));
         end
         OP_BIAS_G: begin
            g_a_ff <= sat32(64'(err_ff) - rnd16(prod_a_ff));
            g_b_ff <= sat32(64'(err_ff) - rnd16(prod_b_ff));
         end
         OP_LOAD: begin
            pred_ff <= '0;
            err_ff  <= '0;
            st_ff   <= ~load_ok;
         end
         OP_ABORT: begin
            pred_ff <= is_pt ? global_mean_ff : 32'sd0;
            err_ff  <= '0;
            st_ff   <= 1'b1;
         end
         OP_PRED: begin
            pred_ff <= pred_sum;
            err_ff  <= '0;
            st_ff   <= 1'b0;
         end
         OP_ERR: err_ff <= sat32(64'(req_ff.rating_value) - 64'(pred_ff));
         default: ;
      endcase
   end

   assign rsp_data.prediction = pred_ff;
   assign rsp_data.error      = err_ff;
   assign rsp_data.status     = st_ff;

endmodule

[hdl/matrix_factorization_sgd_update.sv]
// ----------------------------------------------------------------------------
// matrix_factorization_sgd_update
// Biased matrix factorization engine: stores factors and biases, predicts
// ratings and applies one SGD step per train command.
// ----------------------------------------------------------------------------
// Usage:
//   A command transfers when start is high and busy is low. Exactly one
//   result follows on rsp_data, marked by rsp_strobe for a single cycle; the
//   receiver must take it then.
//   Configuration is written through csr_write_enable / csr_index /
//   csr_write_data while busy is low; registers take effect immediately.
// Sequence, with K the factors in use: a load or rejected command decodes,
//   then loads or aborts, then strobes. Predict reads the biases, takes K dot
//   product steps and predicts; train then forms the error and takes K update
//   steps and the bias update. One command is in flight at a time; the next
//   is taken the cycle after the strobe. A dot product step reads, multiplies
//   and accumulates; an update step reads, multiplies twice, forms gradients,
//   multiplies again and writes back.
// Reset: synchronous; restores the register defaults and returns to idle.
//   Stored factors and biases are not cleared and must be loaded before use.
// ----------------------------------------------------------------------------
module matrix_factorization_sgd_update #(
   parameter int MAX_USERS   = mfsgd_pkg::DEF_MAX_USERS,
   parameter int MAX_ITEMS   = mfsgd_pkg::DEF_MAX_ITEMS,
   parameter int MAX_FACTORS = mfsgd_pkg::DEF_MAX_FACTORS
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  mfsgd_pkg::req_type  req_data,
   output logic                rsp_strobe,
   output mfsgd_pkg::rsp_type  rsp_data,
   input  logic                csr_write_enable,
   input  logic [2:0]          csr_index,
   input  logic [31:0]         csr_write_data
);
   import mfsgd_pkg::*;

   dp_op_type     op;
   dp_status_type stat;

   mfsgd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .op         (op),
      .stat       (stat)
   );

   mfsgd_datapath #(
      .MAX_USERS   (MAX_USERS),
      .MAX_ITEMS   (MAX_ITEMS),
      .MAX_FACTORS (MAX_FACTORS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_data         (req_data),
      .op               (op),
      .stat             (stat),
      .rsp_data         (rsp_data)
   );

`ifndef NO_ASSERTIONS
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted command did not raise busy");

   a_strobe_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> busy)
      else $error("result strobe while idle");

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> (!rsp_strobe && !busy))
      else $error("result strobe longer than one cycle");

   a_latch_only_idle: assert property (@(posedge clock) disable iff (reset)
      (op == OP_LATCH) |-> !busy)
      else $error("request latched while busy");
`endif

endmodule

[tb/sv/tb_matrix_factorization_sgd_update.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_matrix_factorization_sgd_update
// Self-checking bench for the matrix factorization SGD engine: a directed
// saturation run, then random load/train/predict traffic under a series of
// register settings. Every result is compared against an in-bench predictor.
// ----------------------------------------------------------------------------
module tb_matrix_factorization_sgd_update;
   import mfsgd_pkg::*;

   localparam int NU_MAX    = 1024;
   localparam int NI_MAX    = 1024;
   localparam int NK_MAX    = 32;
   localparam int CYC_LIMIT = 1000000;

   logic    clock;
   logic    reset;
   logic    start = 1'b0;
   logic    busy;
   req_type req_data = '0;
   logic    rsp_strobe;
   rsp_type rsp_data;
   logic    csr_write_enable;
   logic [2:0]  csr_index;
   logic [31:0] csr_write_data;

   matrix_factorization_sgd_update i_dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_data         (req_data),
      .rsp_strobe       (rsp_strobe),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   // predictor state
   logic [10:0]        cfg_nu, cfg_ni;
   logic [5:0]         cfg_nk;
   logic signed [31:0] cfg_gm;
   logic [15:0]        cfg_eta, cfg_lam;
   int                 user_vec [NU_MAX*NK_MAX];
   int                 item_vec [NI_MAX*NK_MAX];
   int                 user_bias [NU_MAX];
   int                 item_bias [NI_MAX];
   bit [31:0]          user_vec_ok [NU_MAX];
   bit [31:0]          item_vec_ok [NI_MAX];
   bit                 user_bias_ok [NU_MAX];
   bit                 item_bias_ok [NI_MAX];

   req_type cmd_q[$];
   rsp_type rsp_expect_q[$];
   int      sent_cnt = 0;
   int      acc_cnt = 0;
   int      gap_left = 0;
   bit      no_idle;
   int      fail_cnt = 0;
   int      cyc_cnt = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic longint rnd16q(input longint v);
      return (v + 64'sd32768) >>> 16;
   endfunction

   function automatic longint clip32(input longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic int eff_count(input int v, input int mx);
      return v < mx ? v : mx;
   endfunction

   function automatic bit [31:0] factor_mask(input int nk);
      return nk >= 32 ? 32'hffffffff : (32'h1 << nk) - 1;
   endfunction

   // true when a train/predict on (u,i) would touch anything never loaded
   function automatic bit needs_load(input int u, input int i);
      int nu, ni;
      bit [31:0] m;
      nu = eff_count(int'(cfg_nu), NU_MAX);
      ni = eff_count(int'(cfg_ni), NI_MAX);
      m = factor_mask(eff_count(int'(cfg_nk), NK_MAX));
      if (u >= nu || i >= ni) return 1'b0;
      return !user_bias_ok[u] || !item_bias_ok[i] ||
             ((user_vec_ok[u] & m) != m) || ((item_vec_ok[i] & m) != m);
   endfunction

   function automatic rsp_type sgd_predict_update(input req_type r);
      rsp_type o;
      int      nu, ni, nk, u, i, f, base_u, base_i;
      longint  gm, eta, lam, ld, rating, pred, err, dot, bu, bi, p, q, gp, gq, gu, gi;
      bit      ok;
      nu = eff_count(int'(cfg_nu), NU_MAX);
      ni = eff_count(int'(cfg_ni), NI_MAX);
      nk = eff_count(int'(cfg_nk), NK_MAX);
      u = int'(r.user_index);
      i = int'(r.item_index);
      f = int'(r.factor_index);
      base_u = u * NK_MAX;
      base_i = i * NK_MAX;
      gm = longint'(cfg_gm);
      eta = longint'(cfg_eta);
      lam = longint'(cfg_lam);
      ld = longint'(r.load_value);
      rating = longint'(r.rating_value);
      pred = 0;
      err = 0;
      o.status = 1'b0;
      case (r.command)
         CMD_LOAD_USER_FACTOR: begin
            ok = u < nu && f < nk;
            if (ok) begin
               user_vec[base_u + f] = int'(ld);
               user_vec_ok[u][f] = 1'b1;
            end
            o.status = !ok;
         end
         CMD_LOAD_ITEM_FACTOR: begin
            ok = i < ni && f < nk;
            if (ok) begin
               item_vec[base_i + f] = int'(ld);
               item_vec_ok[i][f] = 1'b1;
            end
            o.status = !ok;
         end
         CMD_LOAD_USER_BIAS: begin
            ok = u < nu;
            if (ok) begin
               user_bias[u] = int'(ld);
               user_bias_ok[u] = 1'b1;
            end
            o.status = !ok;
         end
         CMD_LOAD_ITEM_BIAS: begin
            ok = i < ni;
            if (ok) begin
               item_bias[i] = int'(ld);
               item_bias_ok[i] = 1'b1;
            end
            o.status = !ok;
         end
         CMD_TRAIN, CMD_PREDICT: begin
            if (u >= nu || i >= ni) begin
               pred = gm;
               o.status = 1'b1;
            end else begin
               bu = longint'(user_bias[u]);
               bi = longint'(item_bias[i]);
               dot = 0;
               for (int k = 0; k < nk; k++)
                  dot += rnd16q(longint'(user_vec[base_u + k]) * item_vec[base_i + k]);
               pred = clip32(gm + bu + bi + dot);
               if (r.command == CMD_TRAIN) begin
                  err = clip32(rating - pred);
                  // both vectors step from their old values
                  for (int k = 0; k < nk; k++) begin
                     p = longint'(user_vec[base_u + k]);
                     q = longint'(item_vec[base_i + k]);
                     gp = clip32(rnd16q(err * q) - rnd16q(lam * p));
                     gq = clip32(rnd16q(err * p) - rnd16q(lam * q));
                     user_vec[base_u + k] = int'(clip32(p + rnd16q(eta * gp)));
                     item_vec[base_i + k] = int'(clip32(q + rnd16q(eta * gq)));
                  end
                  gu = clip32(err - rnd16q(lam * bu));
                  gi = clip32(err - rnd16q(lam * bi));
                  user_bias[u] = int'(clip32(bu + rnd16q(eta * gu)));
                  item_bias[i] = int'(clip32(bi + rnd16q(eta * gi)));
               end
            end
         end
         default: o.status = 1'b1;
      endcase
      o.prediction = pred[31:0];
      o.error = err[31:0];
      return o;
   endfunction

   task automatic send_cmd(input req_type r);
      rsp_expect_q.push_back(sgd_predict_update(r));
      cmd_q.push_back(r);
   endtask

   task automatic send_fields(input logic [2:0] c, input int u, input int i, input int f,
                              input logic [31:0] ld, input logic [31:0] rt);
      req_type r;
      r.command = c;
      r.user_index = 10'(u);
      r.item_index = 10'(i);
      r.factor_index = 5'(f);
      r.load_value = ld;
      r.rating_value = rt;
      send_cmd(r);
   endtask

   function automatic logic [31:0] rand_q16();
      if ($urandom_range(0, 7) == 0) return $urandom;
      return $urandom_range(0, 6 << 16) - (3 << 16);
   endfunction

   function automatic int pick_index();
      if ($urandom_range(0, 99) < 85) return $urandom_range(0, 3);
      return $urandom_range(1022, 1023);
   endfunction

   // load whatever a train/predict on (u,i) would read
   task automatic fill_pair(input int u, input int i);
      int nk;
      bit u_in, i_in;
      nk = eff_count(int'(cfg_nk), NK_MAX);
      u_in = u < eff_count(int'(cfg_nu), NU_MAX);
      i_in = i < eff_count(int'(cfg_ni), NI_MAX);
      for (int k = 0; k < nk; k++) begin
         if (u_in && !user_vec_ok[u][k])
            send_fields(CMD_LOAD_USER_FACTOR, u, i, k, rand_q16(), $urandom);
         if (i_in && !item_vec_ok[i][k])
            send_fields(CMD_LOAD_ITEM_FACTOR, u, i, k, rand_q16(), $urandom);
      end
      if (u_in && !user_bias_ok[u])
         send_fields(CMD_LOAD_USER_BIAS, u, i, 0, rand_q16(), $urandom);
      if (i_in && !item_bias_ok[i])
         send_fields(CMD_LOAD_ITEM_BIAS, u, i, 0, rand_q16(), $urandom);
   endtask

   task automatic wait_idle();
      wait (cmd_q.size() == 0 && rsp_expect_q.size() == 0);
      @(negedge clock);
      while (start || busy) @(negedge clock);
   endtask

   task automatic csr_set(input logic [2:0] idx, input logic [31:0] val);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= val;
      case (idx)
         CSR_NUM_USERS:      cfg_nu = val[10:0];
         CSR_NUM_ITEMS:      cfg_ni = val[10:0];
         CSR_NUM_FACTORS:    cfg_nk = val[5:0];
         CSR_GLOBAL_MEAN:    cfg_gm = val;
         CSR_LEARNING_RATE:  cfg_eta = val[15:0];
         CSR_REGULARIZATION: cfg_lam = val[15:0];
         default: ;
      endcase
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic set_all(input int nu, input int ni, input int nk, input logic [31:0] gm,
                          input int eta, input int lam);
      csr_set(CSR_NUM_USERS, nu);
      csr_set(CSR_NUM_ITEMS, ni);
      csr_set(CSR_NUM_FACTORS, nk);
      csr_set(CSR_GLOBAL_MEAN, gm);
      csr_set(CSR_LEARNING_RATE, eta);
      csr_set(CSR_REGULARIZATION, lam);
   endtask

   task automatic random_item();
      req_type r;
      logic [95:0] raw;
      int u, i, sel;
      sel = $urandom_range(0, 99);
      if (sel < 70) begin
         u = pick_index();
         i = pick_index();
         if (sel < 20) begin
            send_fields(3'($urandom_range(0, 3)), u, i,
                        $urandom_range(0, eff_count(int'(cfg_nk), NK_MAX) + 1) % 32,
                        rand_q16(), $urandom);
         end else begin
            fill_pair(u, i);
            send_fields(sel < 55 ? CMD_TRAIN : CMD_PREDICT, u, i, $urandom_range(0, 31),
                        $urandom, rand_q16());
         end
      end else begin
         raw = {$urandom, $urandom, $urandom};
         r = raw[$bits(req_type)-1:0];
         // never read an entry that was never loaded
         if ((r.command == CMD_TRAIN || r.command == CMD_PREDICT) &&
             needs_load(int'(r.user_index), int'(r.item_index)))
            r.command = 3'($urandom_range(0, 3));
         send_cmd(r);
      end
   endtask

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (no_idle || r < 50) return 0;
      if (r < 90) return $urandom_range(1, 4);
      return $urandom_range(20, 80);
   endfunction

   // driver
   always @(negedge clock) begin
      if (!reset) begin
         if (start && acc_cnt == sent_cnt) begin
            gap_left <= pick_gap();
            if (cmd_q.size() > 0 && (no_idle || $urandom_range(0, 1) == 0)) begin
               req_data <= cmd_q.pop_front();
               sent_cnt <= sent_cnt + 1;
            end else begin
               start <= 1'b0;
            end
         end else if (!start) begin
            if (gap_left > 0) begin
               gap_left <= gap_left - 1;
            end else if (cmd_q.size() > 0) begin
               req_data <= cmd_q.pop_front();
               start <= 1'b1;
               sent_cnt <= sent_cnt + 1;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      rsp_type e;
      cyc_cnt <= cyc_cnt + 1;
      if (cyc_cnt > CYC_LIMIT) begin
         $display("matrix_factorization_sgd_update: mismatch");
         $finish;
      end
      if (!reset) begin
         if (start && !busy) acc_cnt <= acc_cnt + 1;
         if (rsp_strobe) begin
            if (rsp_expect_q.size() == 0) begin
               $display("%0t: unexpected result %h", $time, rsp_data);
               fail_cnt++;
            end else begin
               e = rsp_expect_q.pop_front();
               if (rsp_data.prediction !== e.prediction) begin
                  $display("%0t: prediction exp %h got %h", $time, e.prediction,
                           rsp_data.prediction);
                  fail_cnt++;
               end
               if (rsp_data.error !== e.error) begin
                  $display("%0t: error exp %h got %h", $time, e.error, rsp_data.error);
                  fail_cnt++;
               end
               if (rsp_data.status !== e.status) begin
                  $display("%0t: status exp %b got %b", $time, e.status, rsp_data.status);
                  fail_cnt++;
               end
            end
         end
      end
   end

   initial begin
      reset = 1'b1;
      csr_write_enable = 1'b0;
      csr_index = '0;
      csr_write_data = '0;
      no_idle = 1'b0;
      cfg_nu = 11'd1024;
      cfg_ni = 11'd1024;
      cfg_nk = 6'd32;
      cfg_gm = '0;
      cfg_eta = 16'd655;
      cfg_lam = 16'd1311;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: saturation at the top indices, bad factor index, unused codes
      set_all(1024, 1024, 2, 32'h7fff0000, 65535, 65535);
      send_fields(CMD_LOAD_USER_FACTOR, 1023, 1023, 0, 32'h7fffffff, 0);
      send_fields(CMD_LOAD_USER_FACTOR, 1023, 1023, 1, 32'h80000000, 0);
      send_fields(CMD_LOAD_ITEM_FACTOR, 1023, 1023, 0, 32'h7fffffff, 0);
      send_fields(CMD_LOAD_ITEM_FACTOR, 1023, 1023, 1, 32'h7fffffff, 0);
      send_fields(CMD_LOAD_USER_BIAS, 1023, 1023, 0, 32'h80000000, 0);
      send_fields(CMD_LOAD_ITEM_BIAS, 1023, 1023, 0, 32'h7fffffff, 0);
      send_fields(CMD_PREDICT, 1023, 1023, 0, 0, 0);
      send_fields(CMD_TRAIN, 1023, 1023, 0, 0, 32'h80000000);
      send_fields(CMD_TRAIN, 1023, 1023, 31, 32'hffffffff, 32'h7fffffff);
      send_fields(CMD_PREDICT, 1023, 1023, 0, 0, 0);
      send_fields(CMD_LOAD_USER_FACTOR, 0, 0, 2, 32'h12345678, 0);
      send_fields(CMD_LOAD_ITEM_FACTOR, 0, 0, 31, 32'h12345678, 0);
      send_fields(3'd6, 5, 5, 5, $urandom, $urandom);
      send_fields(3'd7, 1023, 1023, 31, $urandom, $urandom);
      send_fields(CMD_LOAD_USER_BIAS, 0, 0, 0, 0, 0);
      send_fields(CMD_LOAD_ITEM_BIAS, 0, 0, 0, 0, 0);
      for (int k = 0; k < 2; k++) begin
         send_fields(CMD_LOAD_USER_FACTOR, 0, 0, k, 0, 0);
         send_fields(CMD_LOAD_ITEM_FACTOR, 0, 0, k, 0, 0);
      end
      send_fields(CMD_TRAIN, 0, 0, 0, 0, 32'h00030000);
      send_fields(CMD_PREDICT, 0, 1023, 0, 0, 0);

      for (int ph = 0; ph < 8; ph++) begin
         wait_idle();
         case (ph)
            0: set_all(1024, 1024, 32, 0, 655, 1311);
            1: set_all(8, 8, 4, 32'h00030000, 6554, 655);
            2: set_all(1, 1, 1, 32'h80000000, 65535, 0);
            3: set_all(2047, 2047, 63, 32'h7fffffff, 0, 65535);
            4: set_all(0, 4, 8, rand_q16(), 1000, 2000);
            5: set_all(6, 1024, 0, rand_q16(), 30000, 100);
            6: set_all(5, 5, 16, rand_q16(), $urandom_range(0, 65535),
                       $urandom_range(0, 65535));
            default: set_all(1024, 3, 32, 32'hfffe0000, 655, 1311);
         endcase
         no_idle = (ph == 1 || ph == 6);
         for (int n = 0; n < 36; n++) begin
            // hold off once until everything outstanding has come back
            if (ph == 3 && n == 18) wait_idle();
            random_item();
         end
      end

      wait (cmd_q.size() == 0 && rsp_expect_q.size() == 0);
      repeat (400) @(posedge clock);
      if (fail_cnt == 0 && rsp_expect_q.size() == 0)
         $display("matrix_factorization_sgd_update: match");
      else
         $display("matrix_factorization_sgd_update: mismatch");
      $finish;
   end

endmodule
